FILE: rtl/pic_pkg.sv
// shared types and constants for the inline cache slot
`default_nettype none

package pic_pkg;

  localparam int PIC_POLY_CAPACITY = 4;
  localparam int PIC_WORD_W        = 32;
  localparam int PIC_COUNT_OUT_W   = 3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  typedef enum logic [1:0] {
    SLOT_UNINIT = 2'd0,
    SLOT_MONO   = 2'd1,
    SLOT_POLY   = 2'd2,
    SLOT_MEGA   = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_RESP
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } pic_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/polymorphic_inline_cache_slot.sv
// top level of the inline cache slot: sequencer plus slot datapath
//
//   channel   ports                                          handshake
//   command   opcode, class_id, target_value                 start, busy
//   result    hit, target_out, slot_state, entry_count       done (one-cycle strobe)
//
// a command word is taken at a clock edge with start high and busy low
// the cycle after that edge runs the compare and update logic; the result
// shows with done in the following cycle
// while done is high busy is low, so a new word can be taken while the result is shown
// the receiver cannot stall; results are lost if not taken on the done cycle
// synchronous reset leaves the slot uninitialised with no entries in use
`default_nettype none

module polymorphic_inline_cache_slot
  import pic_pkg::*;
#(
  parameter int POLY_CAPACITY = PIC_POLY_CAPACITY
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      opcode,
  input  wire logic [PIC_WORD_W-1:0]     class_id,
  input  wire logic [PIC_WORD_W-1:0]     target_value,
  output logic                           done,
  output logic                           hit,
  output logic [PIC_WORD_W-1:0]          target_out,
  output logic [1:0]                     slot_state,
  output logic [PIC_COUNT_OUT_W-1:0]     entry_count
);

  // commands from the sequencer into the datapath
  pic_cmd_t cmd;

  // sequencer: idle, execute, respond
  pic_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // entries, parallel compare and mono/poly/mega transitions
  pic_datapath #(
    .POLY_CAPACITY (POLY_CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .opcode       (opcode),
    .class_id     (class_id),
    .target_value (target_value),
    .hit          (hit),
    .target_out   (target_out),
    .slot_state   (slot_state),
    .entry_count  (entry_count)
  );

endmodule

`default_nettype wire

FILE: rtl/pic_ctrl.sv
// sequencer: capture, execute, respond
`default_nettype none

module pic_ctrl
  import pic_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  output logic          done,
  output pic_cmd_t      cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      CTL_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = CTL_EXEC;
        end
      end
      CTL_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = CTL_RESP;
      end
      CTL_RESP: begin
        done = 1'b1;
        // next word may be taken while this result is shown
        if (start) begin
          cmd.load   = 1'b1;
          state_next = CTL_EXEC;
        end else begin
          state_next = CTL_IDLE;
        end
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

  // every execute cycle is followed by exactly one result strobe
  assert property (@(posedge clk) disable iff (rst) cmd.exec |=> done)
    else $error("execute not followed by result");
  // a result strobe only ever follows an execute cycle
  assert property (@(posedge clk) disable iff (rst) done |-> $past(cmd.exec))
    else $error("result without execute");
  // busy and the result strobe are never high together
  assert property (@(posedge clk) disable iff (rst) !(busy && done))
    else $error("busy during result strobe");

endmodule

`default_nettype wire

FILE: rtl/pic_datapath.sv
// slot storage, class compare and slot state update
`default_nettype none

module pic_datapath
  import pic_pkg::*;
#(
  parameter int POLY_CAPACITY = PIC_POLY_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pic_cmd_t                      cmd,
  input  wire logic                          opcode,
  input  wire logic [PIC_WORD_W-1:0]         class_id,
  input  wire logic [PIC_WORD_W-1:0]         target_value,
  output logic                               hit,
  output logic [PIC_WORD_W-1:0]              target_out,
  output logic [1:0]                         slot_state,
  output logic [PIC_COUNT_OUT_W-1:0]         entry_count
);

  localparam int CW = $clog2(POLY_CAPACITY + 1);
  localparam int IW = $clog2(POLY_CAPACITY);

  // captured command word
  logic                  op_q;
  logic [PIC_WORD_W-1:0] cls_q;
  logic [PIC_WORD_W-1:0] tv_q;

  slot_state_t           cache_state;
  slot_state_t           cache_state_next;
  logic [CW-1:0]         poly_used;
  logic [CW-1:0]         poly_used_next;
  logic [PIC_WORD_W-1:0] mono_class;
  logic [PIC_WORD_W-1:0] mono_target;
  logic [PIC_WORD_W-1:0] poly_class  [POLY_CAPACITY];
  logic [PIC_WORD_W-1:0] poly_target [POLY_CAPACITY];

  logic [POLY_CAPACITY-1:0] match_vec;
  logic [POLY_CAPACITY-1:0] match_first;
  logic                     poly_found;
  logic [PIC_WORD_W-1:0]    poly_tgt;
  logic                     mono_match;
  logic                     poly_full;
  logic                     mono_wr;
  logic                     promote;
  logic                     append;
  logic                     hit_next;
  logic [PIC_WORD_W-1:0]    tgt_next;
  logic [CW+PIC_COUNT_OUT_W-1:0] count_ext;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      cls_q <= class_id;
      tv_q  <= target_value;
    end
  end

  // parallel compare against live entries, lowest index wins
  always_comb begin
    for (int i = 0; i < POLY_CAPACITY; i++) begin
      match_vec[i] = (CW'(i) < poly_used) && (poly_class[i] == cls_q);
    end
  end

  assign match_first = match_vec & (~match_vec + POLY_CAPACITY'(1));
  assign poly_found  = |match_vec;

  always_comb begin
    poly_tgt = '0;
    for (int i = 0; i < POLY_CAPACITY; i++) begin
      poly_tgt = poly_tgt | ({PIC_WORD_W{match_first[i]}} & poly_target[i]);
    end
  end

  assign mono_match = (mono_class == cls_q);
  assign poly_full  = (poly_used == CW'(POLY_CAPACITY));

  always_comb begin
    cache_state_next = cache_state;
    poly_used_next   = poly_used;
    mono_wr          = 1'b0;
    promote          = 1'b0;
    append           = 1'b0;
    hit_next         = 1'b0;
    tgt_next         = '0;
    if (cmd.exec) begin
      if (op_q == OP_LOOKUP) begin
        case (cache_state)
          SLOT_MONO: begin
            hit_next = mono_match;
            tgt_next = mono_match ? mono_target : '0;
          end
          SLOT_POLY: begin
            hit_next = poly_found;
            tgt_next = poly_tgt;
          end
          default: begin
            hit_next = 1'b0;
          end
        endcase
      end else begin
        case (cache_state)
          SLOT_UNINIT: begin
            cache_state_next = SLOT_MONO;
            mono_wr          = 1'b1;
          end
          SLOT_MONO: begin
            if (!mono_match) begin
              cache_state_next = SLOT_POLY;
              promote          = 1'b1;
              poly_used_next   = CW'(2);
            end
          end
          SLOT_POLY: begin
            if (poly_full) begin
              cache_state_next = SLOT_MEGA;
            end else if (!poly_found) begin
              append         = 1'b1;
              poly_used_next = poly_used + CW'(1);
            end
          end
          default: begin
            cache_state_next = cache_state;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_state <= SLOT_UNINIT;
      poly_used   <= '0;
    end else begin
      cache_state <= cache_state_next;
      poly_used   <= poly_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mono_wr) begin
      mono_class  <= cls_q;
      mono_target <= tv_q;
    end
    if (promote) begin
      // old mono entry first, new class second
      poly_class[0]      <= mono_class;
      poly_target[0]     <= mono_target;
      poly_class[1]      <= cls_q;
      poly_target[1]     <= tv_q;
    end
    if (append) begin
      poly_class[poly_used[IW-1:0]]  <= cls_q;
      poly_target[poly_used[IW-1:0]] <= tv_q;
    end
    if (cmd.exec) begin
      hit        <= hit_next;
      target_out <= tgt_next;
    end
  end

  assign count_ext   = {{PIC_COUNT_OUT_W{1'b0}}, poly_used};
  assign slot_state  = cache_state;
  assign entry_count = count_ext[PIC_COUNT_OUT_W-1:0];

  // a poly slot always holds between two and capacity entries
  assert property (@(posedge clk) disable iff (rst)
    (cache_state == SLOT_POLY) |->
      ((poly_used >= CW'(2)) && (poly_used <= CW'(POLY_CAPACITY))))
    else $error("poly entry count out of range");
  // slot state only moves in an execute cycle
  assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.exec) |-> $stable(cache_state))
    else $error("slot state changed outside execute");
  // a miss or a record always carries a zero target
  assert property (@(posedge clk) disable iff (rst)
    ($past(cmd.exec) && !hit) |-> (target_out == '0))
    else $error("nonzero target on miss");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the inline cache slot: random and directed command words
`default_nettype none

module testbench
  import pic_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 500;  // cycles with no word taken and no reply
  localparam int SETTLE_CYCLES = 8;  // wait after the last reply is due, plus margin
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // rec_mode of a random phase: which records may appear
  localparam int REC_NONE = 0;  // lookups only
  localparam int REC_KNOWN = 1; // records of classes already held, no state change
  localparam int REC_ANY = 2;   // anything goes (megamorphic slot)

  // one command word as queued for the driver
  typedef struct {
    logic        op;
    logic [31:0] cls;
    logic [31:0] tv;
    int          gap;    // idle cycles before the word is offered
    bit          drain;  // hold the word back until every reply is in
  } cache_cmd_t;

  // one predicted reply
  typedef struct {
    logic                       hit;
    logic [31:0]                tgt;
    slot_state_t                st;
    logic [PIC_COUNT_OUT_W-1:0] cnt;
  } slot_reply_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       opcode = OP_LOOKUP;
  logic [PIC_WORD_W-1:0]      class_id = '0;
  logic [PIC_WORD_W-1:0]      target_value = '0;
  logic                       busy;
  logic                       done;
  logic                       hit;
  logic [PIC_WORD_W-1:0]      target_out;
  logic [1:0]                 slot_state;
  logic [PIC_COUNT_OUT_W-1:0] entry_count;

  cache_cmd_t  cmd_backlog[$];     // words still to be offered
  slot_reply_t replies_due[$];     // predicted replies, oldest first
  logic [31:0] held_classes[$];    // generator's view of the classes in the slot

  int          slot_faults = 0;
  int          quiet_cycles = 0;
  int          idle_count = 0;     // idle cycles spent before the next word
  int          calm_left = 0;      // words left in a stretch with no idling
  cache_cmd_t  next_cmd;

  // predictor's own copy of the slot
  slot_state_t model_st = SLOT_UNINIT;
  logic [31:0] model_mono_cls = '0;
  logic [31:0] model_mono_tgt = '0;
  int          model_poly_cnt = 0;
  logic [31:0] model_poly_cls[PIC_POLY_CAPACITY];
  logic [31:0] model_poly_tgt[PIC_POLY_CAPACITY];

  polymorphic_inline_cache_slot i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .class_id     (class_id),
    .target_value (target_value),
    .done         (done),
    .hit          (hit),
    .target_out   (target_out),
    .slot_state   (slot_state),
    .entry_count  (entry_count)
  );

  always #5 clk = ~clk;

  // step the predicted slot by one word and return the reply it should give
  function automatic slot_reply_t predict_slot_word(logic op, logic [31:0] cls,
                                                    logic [31:0] tv);
    slot_reply_t r;
    bit          found;
    logic [31:0] found_tgt;
    found = 1'b0;
    found_tgt = '0;
    r.hit = 1'b0;
    r.tgt = '0;
    // lowest matching entry wins; only entries in use are searched
    if (model_st == SLOT_POLY) begin
      for (int i = 0; i < PIC_POLY_CAPACITY; i++) begin
        if (!found && i < model_poly_cnt && model_poly_cls[i] == cls) begin
          found = 1'b1;
          found_tgt = model_poly_tgt[i];
        end
      end
    end
    if (op == OP_LOOKUP) begin
      if (model_st == SLOT_MONO && model_mono_cls == cls) begin
        r.hit = 1'b1;
        r.tgt = model_mono_tgt;
      end else if (model_st == SLOT_POLY && found) begin
        r.hit = 1'b1;
        r.tgt = found_tgt;
      end
    end else begin
      case (model_st)
        SLOT_UNINIT: begin
          model_st = SLOT_MONO;
          model_mono_cls = cls;
          model_mono_tgt = tv;
        end
        SLOT_MONO: begin
          // a second class: old entry first, new entry second
          if (model_mono_cls != cls) begin
            model_st = SLOT_POLY;
            model_poly_cls[0] = model_mono_cls;
            model_poly_tgt[0] = model_mono_tgt;
            model_poly_cls[1] = cls;
            model_poly_tgt[1] = tv;
            model_poly_cnt = 2;
          end
        end
        SLOT_POLY: begin
          // a full table goes megamorphic even for a class it already holds
          if (model_poly_cnt < PIC_POLY_CAPACITY) begin
            if (!found) begin
              model_poly_cls[model_poly_cnt] = cls;
              model_poly_tgt[model_poly_cnt] = tv;
              model_poly_cnt++;
            end
          end else begin
            model_st = SLOT_MEGA;
          end
        end
        default: begin
        end
      endcase
    end
    r.st = model_st;
    r.cnt = model_poly_cnt[PIC_COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_fault(string what);
    slot_faults++;
    if (slot_faults <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // queue one word; idling is drawn here, with occasional stretches of none
  task automatic queue_word(logic op, logic [31:0] cls, logic [31:0] tv, bit drain = 1'b0);
    cache_cmd_t c;
    c.op = op;
    c.cls = cls;
    c.tv = tv;
    c.drain = drain;
    if (calm_left > 0) begin
      calm_left--;
      c.gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 40);
      c.gap = 0;
    end else begin
      c.gap = $urandom_range(0, 5);
    end
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  // note a class as held by the slot
  task automatic remember_class(logic [31:0] cls);
    held_classes.insert(held_classes.size(), cls);
  endtask

  function automatic bit is_held(logic [31:0] cls);
    foreach (held_classes[i]) if (held_classes[i] == cls) return 1'b1;
    return 1'b0;
  endfunction

  // a random class not yet in the slot
  function automatic logic [31:0] fresh_class();
    logic [31:0] c;
    c = $urandom;
    while (is_held(c)) c = $urandom;
    return c;
  endfunction

  // lookup class: mostly held ones, some random, near misses and extremes
  function automatic logic [31:0] pick_lookup_class();
    int roll;
    roll = $urandom_range(0, 99);
    if (held_classes.size() != 0 && roll < 55)
      return held_classes[$urandom_range(0, held_classes.size() - 1)];
    if (held_classes.size() != 0 && roll < 70)
      return held_classes[$urandom_range(0, held_classes.size() - 1)]
             ^ (32'd1 << $urandom_range(0, 31));
    if (roll < 78) return ($urandom_range(0, 1) != 0) ? ALL_ONES : 32'd0;
    return $urandom;
  endfunction

  task automatic random_phase(int n, int rec_mode);
    logic [31:0] cls;
    for (int k = 0; k < n; k++) begin
      if (rec_mode != REC_NONE && $urandom_range(0, 99) < 30) begin
        if (rec_mode == REC_KNOWN)
          cls = held_classes[$urandom_range(0, held_classes.size() - 1)];
        else
          cls = pick_lookup_class();
        queue_word(OP_RECORD, cls, $urandom);
      end else begin
        queue_word(OP_LOOKUP, pick_lookup_class(), $urandom);
      end
    end
  endtask

  // driver: offers queued words, holds each until busy is low at an edge
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      opcode <= OP_LOOKUP;
      class_id <= '0;
      target_value <= '0;
      idle_count <= 0;
    end else if (!(start && busy)) begin
      // either nothing was offered or the word went in at this edge
      if (cmd_backlog.size() != 0 && idle_count >= cmd_backlog[0].gap &&
          (!cmd_backlog[0].drain || (!start && replies_due.size() == 0))) begin
        next_cmd = cmd_backlog.pop_front();
        start <= 1'b1;
        opcode <= next_cmd.op;
        class_id <= next_cmd.cls;
        target_value <= next_cmd.tv;
        idle_count <= 0;
      end else begin
        start <= 1'b0;
        if (cmd_backlog.size() != 0 && idle_count < cmd_backlog[0].gap)
          idle_count <= idle_count + 1;
      end
    end
  end

  // monitor: checks each reply against the oldest prediction, then predicts
  // the word taken at this edge (a reply and a new word can share an edge)
  always @(posedge clk) begin
    slot_reply_t want;
    if (rst) begin
      model_st = SLOT_UNINIT;
      model_poly_cnt = 0;
    end else begin
      if (done) begin
        if (replies_due.size() == 0) begin
          report_fault("reply with no word outstanding");
        end else begin
          want = replies_due.pop_front();
          if (hit !== want.hit || target_out !== want.tgt ||
              slot_state !== want.st || entry_count !== want.cnt)
            report_fault($sformatf({"expected hit=%0b target=%h state=%0d count=%0d, ",
                                    "got hit=%0b target=%h state=%0d count=%0d"},
                                   want.hit, want.tgt, want.st, want.cnt,
                                   hit, target_out, slot_state, entry_count));
        end
      end
      if (start && !busy)
        replies_due.insert(replies_due.size(),
                           predict_slot_word(opcode, class_id, target_value));
    end
  end

  // watchdog: ends the run if the handshakes stall
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** polymorphic_inline_cache_slot: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus: the slot only ever climbs uninitialised, mono, poly, mega, and
  // reset comes once, so each state gets its own random stretch in that order
  initial begin
    logic [31:0] cls_a;
    logic [31:0] cls_b;
    logic [31:0] cls_c;
    logic [31:0] cls_d;
    cls_a = ALL_ONES;
    cls_b = 32'd0;

    // uninitialised: every lookup misses
    queue_word(OP_LOOKUP, 32'd0, ALL_ONES);
    queue_word(OP_LOOKUP, ALL_ONES, 32'd0);
    random_phase(20, REC_NONE);

    // first record makes the slot monomorphic
    queue_word(OP_RECORD, cls_a, 32'd0, 1'b1);
    remember_class(cls_a);
    queue_word(OP_LOOKUP, cls_a, $urandom);
    queue_word(OP_LOOKUP, 32'd0, $urandom);
    queue_word(OP_LOOKUP, 32'h7FFF_FFFF, $urandom);
    // known class while mono: target must not change
    queue_word(OP_RECORD, cls_a, ALL_ONES);
    queue_word(OP_LOOKUP, cls_a, $urandom);
    random_phase(150, REC_KNOWN);

    // second class: poly with the old entry first
    queue_word(OP_RECORD, cls_b, ALL_ONES, 1'b1);
    remember_class(cls_b);
    queue_word(OP_LOOKUP, cls_b, 32'd0);
    queue_word(OP_LOOKUP, cls_a, 32'd0);
    queue_word(OP_RECORD, cls_b, 32'd0);
    queue_word(OP_LOOKUP, cls_b, ALL_ONES);
    random_phase(150, REC_KNOWN);

    cls_c = fresh_class();
    queue_word(OP_RECORD, cls_c, 32'h5555_5555, 1'b1);
    remember_class(cls_c);
    queue_word(OP_LOOKUP, cls_c, $urandom);
    random_phase(150, REC_KNOWN);

    // table full: no records until the one that tips it over
    cls_d = fresh_class();
    queue_word(OP_RECORD, cls_d, 32'hAAAA_AAAA, 1'b1);
    remember_class(cls_d);
    queue_word(OP_LOOKUP, cls_d, $urandom);
    queue_word(OP_LOOKUP, cls_a, $urandom);
    random_phase(200, REC_NONE);

    // record of a class already held on a full table: megamorphic
    queue_word(OP_RECORD, cls_a, 32'd0, 1'b1);
    queue_word(OP_LOOKUP, cls_a, $urandom);
    queue_word(OP_LOOKUP, cls_d, $urandom);
    queue_word(OP_RECORD, fresh_class(), $urandom);
    random_phase(150, REC_ANY);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) report_fault("predicted replies never arrived");

    if (slot_faults == 0) begin
      $display("** polymorphic_inline_cache_slot: PASSED **");
    end else begin
      $display("** polymorphic_inline_cache_slot: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/pic_pkg.sv
rtl/pic_ctrl.sv
rtl/pic_datapath.sv
rtl/polymorphic_inline_cache_slot.sv
sim/testbench.sv
